// File: sv/height_grid_neighbor_query_macros.svh
// Assertion macros shared by the height grid RTL
`ifndef HEIGHT_GRID_NEIGHBOR_QUERY_MACROS_SVH
`define HEIGHT_GRID_NEIGHBOR_QUERY_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HGNQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hgnq check failed");
// next-cycle implication
`define HGNQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hgnq check failed");
`else
`define HGNQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define HGNQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/hgnq_pkg.sv
// Types and constants of the height grid neighbour query block
`timescale 1ns / 1ps
`default_nettype none
package hgnq_pkg;

  // widest cell index the command queue carries (1024 x 1024 grid)
  localparam int CMD_ADDR_W = 20;

  // input actions
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_FOUND = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;
  localparam logic [1:0] KIND_OOB   = 2'd3;

  // queued command kinds
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_OOB   = 2'd3;

  // configuration register indexes and reset values
  localparam logic [1:0]  REG_WIDTH     = 2'd0;
  localparam logic [1:0]  REG_DEPTH     = 2'd1;
  localparam logic [1:0]  REG_THRESHOLD = 2'd2;
  localparam logic [6:0]  WIDTH_RST     = 7'd64;
  localparam logic [6:0]  DEPTH_RST     = 7'd64;
  localparam logic [16:0] THRESHOLD_RST = 17'd0;

  // effective configuration seen by front and back
  typedef struct packed {
    logic [6:0]  eff_width;
    logic [6:0]  eff_depth;
    logic [16:0] threshold;
  } cfg_t;

  // one classified command in the queue
  typedef struct packed {
    logic [1:0]            kind;
    logic [5:0]            pos_x;
    logic [5:0]            pos_y;
    logic [CMD_ADDR_W-1:0] addr;
    logic signed [15:0]    height_in;
    logic [3:0]            nbr_ok;   // +y, -y, +x, -x inside the grid
  } cmd_t;

endpackage
`default_nettype wire

// File: sv/hgnq_if.sv
// Valid/ready channel interfaces for the input and result beats
`timescale 1ns / 1ps
`default_nettype none
interface hgnq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [5:0]         pos_x;
  logic [5:0]         pos_y;
  logic signed [15:0] height_in;

  modport source (output valid, action, pos_x, pos_y, height_in, input ready);
  modport sink   (input valid, action, pos_x, pos_y, height_in, output ready);
endinterface

interface hgnq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [5:0]         neighbor_x;
  logic [5:0]         neighbor_y;
  logic signed [15:0] height_out;
  logic               last;

  modport source (output valid, result_kind, neighbor_x, neighbor_y, height_out, last,
                  input ready);
  modport sink   (input valid, result_kind, neighbor_x, neighbor_y, height_out, last,
                  output ready);
endinterface
`default_nettype wire

// File: sv/hgnq_front.sv
// Front end: accepts input beats, bounds-checks them and builds queue commands
`timescale 1ns / 1ps
`default_nettype none
module hgnq_front (
  input  hgnq_pkg::cfg_t cfg,
  hgnq_in_if.sink        in_ch,
  output logic           push,
  output hgnq_pkg::cmd_t push_cmd,
  input  logic           full
);
  import hgnq_pkg::*;

  logic        accept;
  logic        in_bounds;
  logic        keep;
  logic [12:0] row_base;
  logic [6:0]  x_ext;
  logic [6:0]  y_ext;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  assign x_ext     = {1'b0, in_ch.pos_x};
  assign y_ext     = {1'b0, in_ch.pos_y};
  assign in_bounds = (x_ext < cfg.eff_width) && (y_ext < cfg.eff_depth);

  // row-major cell index
  assign row_base = 13'(in_ch.pos_y) * 13'(cfg.eff_width);

  // classify the beat
  always_comb begin
    keep              = 1'b0;
    push_cmd.kind     = CMD_OOB;
    push_cmd.pos_x    = in_ch.pos_x;
    push_cmd.pos_y    = in_ch.pos_y;
    push_cmd.addr     = CMD_ADDR_W'(row_base) + CMD_ADDR_W'(in_ch.pos_x);
    push_cmd.height_in = in_ch.height_in;
    push_cmd.nbr_ok[0] = (y_ext + 7'd1) < cfg.eff_depth;
    push_cmd.nbr_ok[1] = in_ch.pos_y != 6'd0;
    push_cmd.nbr_ok[2] = (x_ext + 7'd1) < cfg.eff_width;
    push_cmd.nbr_ok[3] = in_ch.pos_x != 6'd0;
    case (in_ch.action)
      ACT_WRITE: begin
        keep          = in_bounds;  // out-of-grid writes are dropped
        push_cmd.kind = CMD_WRITE;
      end
      ACT_READ: begin
        keep          = 1'b1;
        push_cmd.kind = in_bounds ? CMD_READ : CMD_OOB;
      end
      ACT_QUERY: begin
        keep          = 1'b1;
        push_cmd.kind = in_bounds ? CMD_QUERY : CMD_OOB;
      end
      default: keep = 1'b0;       // unused action: no command
    endcase
  end

  assign push = accept && keep;

endmodule
`default_nettype wire

// File: sv/hgnq_cmd_fifo.sv
// Two-entry command queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none
`include "height_grid_neighbor_query_macros.svh"
module hgnq_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hgnq_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output hgnq_pkg::cmd_t head_cmd
);
  import hgnq_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full       = count_r == 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head_cmd   = slot_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

  `HGNQ_ASSERT_NOW(a_no_push_when_full, clk, rst_n, push, !full)
  `HGNQ_ASSERT_NOW(a_no_pop_when_empty, clk, rst_n, pop, head_valid)
  `HGNQ_ASSERT_NOW(a_count_in_range, clk, rst_n, 1'b1, count_r != 2'd3)

endmodule
`default_nettype wire

// File: sv/hgnq_back.sv
// Back end: height memory, neighbour sequencer and result register
`timescale 1ns / 1ps
`default_nettype none
`include "height_grid_neighbor_query_macros.svh"
module hgnq_back #(
  parameter int MAX_WIDTH   = 64,
  parameter int MAX_DEPTH   = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  hgnq_pkg::cfg_t cfg,
  input  logic           head_valid,
  input  hgnq_pkg::cmd_t head_cmd,
  output logic           pop,
  hgnq_out_if.source     out_ch
);
  import hgnq_pkg::*;

  localparam int CELLS = MAX_WIDTH * MAX_DEPTH;
  localparam int AW    = $clog2(CELLS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_QUERY = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [HEIGHT_BITS-1:0] mem [CELLS];

  logic [1:0]                    state_r, state_nxt;
  cmd_t                          cmd_r;
  logic                          cmd_load;
  logic [2:0]                    step_r, step_nxt;
  logic                          rd_pend_r, rd_pend_nxt;
  logic [2:0]                    rd_tag_r, rd_tag_nxt;
  logic [3:0]                    keep_r, keep_nxt;
  logic signed [HEIGHT_BITS-1:0] rd_data_r;
  logic signed [HEIGHT_BITS-1:0] centre_r;
  logic                          centre_load;

  logic                   mem_we;
  logic                   mem_re;
  logic [AW-1:0]          mem_addr;
  logic [HEIGHT_BITS-1:0] mem_wdata;
  logic [AW-1:0]          base_addr;
  logic [AW-1:0]          row_step;
  logic [AW-1:0]          nbr_addr;

  logic signed [31:0]          rd_ext;
  logic signed [31:0]          hin_ext;
  logic signed [HEIGHT_BITS:0] diff;
  logic [HEIGHT_BITS:0]        mag;
  logic                        close;
  logic [1:0]                  tag_idx;
  logic [1:0]                  sel;

  logic        slot_free;
  logic        emit;
  logic [1:0]  emit_kind;
  logic [5:0]  emit_x;
  logic [5:0]  emit_y;
  logic [15:0] emit_h;
  logic        emit_last;

  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic [5:0]         out_x_r;
  logic [5:0]         out_y_r;
  logic signed [15:0] out_h_r;
  logic               out_last_r;

  assign slot_free = !out_valid_r || out_ch.ready;

  // stored height wraps to HEIGHT_BITS, read back sign-extended
  assign hin_ext   = 32'(head_cmd.height_in);
  assign mem_wdata = HEIGHT_BITS'(hin_ext);
  assign rd_ext    = 32'(rd_data_r);

  // neighbour addresses: +y, -y, +x, -x around the centre
  assign base_addr = AW'(cmd_r.addr);
  assign row_step  = AW'(cfg.eff_width);
  always_comb begin
    case (step_r)
      3'd1:    nbr_addr = base_addr + row_step;
      3'd2:    nbr_addr = base_addr - row_step;
      3'd3:    nbr_addr = base_addr + AW'(1);
      default: nbr_addr = base_addr - AW'(1);
    endcase
  end

  // height difference check against the threshold
  assign diff    = (HEIGHT_BITS+1)'(centre_r) - (HEIGHT_BITS+1)'(rd_data_r);
  assign mag     = diff[HEIGHT_BITS] ? -diff : diff;
  assign close   = 34'(mag) <= 34'(cfg.threshold);
  assign tag_idx = 2'(rd_tag_r - 3'd1);

  // lowest kept neighbour goes out first
  always_comb begin
    if (keep_r[0])      sel = 2'd0;
    else if (keep_r[1]) sel = 2'd1;
    else if (keep_r[2]) sel = 2'd2;
    else                sel = 2'd3;
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    rd_pend_nxt = rd_pend_r;
    rd_tag_nxt  = rd_tag_r;
    keep_nxt    = keep_r;
    cmd_load    = 1'b0;
    centre_load = 1'b0;
    pop         = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = AW'(head_cmd.addr);
    emit        = 1'b0;
    emit_kind   = KIND_READ;
    emit_x      = 6'd0;
    emit_y      = 6'd0;
    emit_h      = 16'd0;
    emit_last   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          case (head_cmd.kind)
            CMD_WRITE: begin
              mem_we = 1'b1;
              pop    = 1'b1;
            end
            CMD_READ: begin
              mem_re    = 1'b1;
              pop       = 1'b1;
              cmd_load  = 1'b1;
              state_nxt = S_READ;
            end
            CMD_QUERY: begin
              // centre read goes out now, neighbours follow
              mem_re      = 1'b1;
              pop         = 1'b1;
              cmd_load    = 1'b1;
              rd_pend_nxt = 1'b1;
              rd_tag_nxt  = 3'd0;
              step_nxt    = 3'd1;
              keep_nxt    = 4'd0;
              state_nxt   = S_QUERY;
            end
            default: begin
              // out of bounds: single error beat
              if (slot_free) begin
                emit      = 1'b1;
                emit_kind = KIND_OOB;
                pop       = 1'b1;
              end
            end
          endcase
        end
      end
      S_READ: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_kind = KIND_READ;
          emit_h    = rd_ext[15:0];
          state_nxt = S_IDLE;
        end
      end
      S_QUERY: begin
        // consume the read issued last cycle
        if (rd_pend_r) begin
          if (rd_tag_r == 3'd0) centre_load = 1'b1;
          else keep_nxt[tag_idx] = cmd_r.nbr_ok[tag_idx] && close;
          if (rd_tag_r == 3'd4) state_nxt = S_EMIT;
        end
        // issue the next neighbour read
        if (step_r <= 3'd4) begin
          mem_re      = 1'b1;
          mem_addr    = nbr_addr;
          rd_pend_nxt = 1'b1;
          rd_tag_nxt  = step_r;
          step_nxt    = step_r + 3'd1;
        end else begin
          rd_pend_nxt = 1'b0;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          emit = 1'b1;
          if (keep_r == 4'd0) begin
            emit_kind = KIND_NONE;
            state_nxt = S_IDLE;
          end else begin
            emit_kind = KIND_FOUND;
            keep_nxt  = keep_r & ~(4'b0001 << sel);
            emit_last = keep_nxt == 4'd0;
            emit_x    = cmd_r.pos_x;
            emit_y    = cmd_r.pos_y;
            case (sel)
              2'd0:    emit_y = cmd_r.pos_y + 6'd1;
              2'd1:    emit_y = cmd_r.pos_y - 6'd1;
              2'd2:    emit_x = cmd_r.pos_x + 6'd1;
              default: emit_x = cmd_r.pos_x - 6'd1;
            endcase
            if (emit_last) state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      step_r    <= 3'd0;
      rd_pend_r <= 1'b0;
      rd_tag_r  <= 3'd0;
      keep_r    <= 4'd0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      rd_pend_r <= rd_pend_nxt;
      rd_tag_r  <= rd_tag_nxt;
      keep_r    <= keep_nxt;
    end
  end

  // held command and centre height
  always_ff @(posedge clk) begin
    if (cmd_load)    cmd_r    <= head_cmd;
    if (centre_load) centre_r <= rd_data_r;
  end

  // height memory, one access a cycle, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= emit_kind;
      out_x_r    <= emit_x;
      out_y_r    <= emit_y;
      out_h_r    <= emit_h;
      out_last_r <= emit_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.neighbor_x  = out_x_r;
  assign out_ch.neighbor_y  = out_y_r;
  assign out_ch.height_out  = out_h_r;
  assign out_ch.last        = out_last_r;

  `HGNQ_ASSERT_NOW(a_write_only_idle, clk, rst_n, mem_we, state_r == S_IDLE)
  `HGNQ_ASSERT_NOW(a_emit_no_pending_read, clk, rst_n, state_r == S_EMIT, !rd_pend_r)
  `HGNQ_ASSERT_NEXT(a_last_tag_to_emit, clk, rst_n,
    state_r == S_QUERY && rd_pend_r && rd_tag_r == 3'd4, state_r == S_EMIT)

endmodule
`default_nettype wire

// File: sv/height_grid_neighbor_query.sv
// Reads pass the registered memory read and the result register; out-of-bounds
// beats go straight to the result register; a query reads the centre and its four
// neighbours in turn; the single-port height memory serves one read per cycle.
// A two-entry command queue lets input beats be taken while the back end works.
// Synchronous active-low reset clears control and sets width 64, depth 64,
// threshold 0; height memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module height_grid_neighbor_query #(
  parameter int MAX_WIDTH   = 64,
  parameter int MAX_DEPTH   = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  hgnq_in_if.sink     in_ch,
  hgnq_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hgnq_pkg::*;

  logic [6:0]  grid_width_r;
  logic [6:0]  grid_depth_r;
  logic [16:0] threshold_r;
  logic        cfg_wr;
  logic [1:0]  reg_idx;
  cfg_t        cfg;

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  // register port
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= WIDTH_RST;
      grid_depth_r <= DEPTH_RST;
      threshold_r  <= THRESHOLD_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WIDTH:     grid_width_r <= cfg_pwdata[6:0];
        REG_DEPTH:     grid_depth_r <= cfg_pwdata[6:0];
        REG_THRESHOLD: threshold_r  <= cfg_pwdata[16:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:     cfg_prdata = 32'(grid_width_r);
      REG_DEPTH:     cfg_prdata = 32'(grid_depth_r);
      REG_THRESHOLD: cfg_prdata = 32'(threshold_r);
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // grid size saturates at the built size
  assign cfg.eff_width = (32'(grid_width_r) > MAX_WIDTH) ? 7'(MAX_WIDTH) : grid_width_r;
  assign cfg.eff_depth = (32'(grid_depth_r) > MAX_DEPTH) ? 7'(MAX_DEPTH) : grid_depth_r;
  assign cfg.threshold = threshold_r;

  hgnq_front u_front (
    .cfg      (cfg),
    .in_ch    (in_ch),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full)
  );

  hgnq_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  hgnq_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_DEPTH   (MAX_DEPTH),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
